FILE: hw/rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse: element count, tolerance
// register format and the cofactor index tables.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int N_ELEM    = 9;
    localparam int TOL_WIDTH = 32;

    // about 1e-7 in units of 2^-32
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd429;

    typedef logic [3:0] elem_idx_t;

    // cofactor i = a[p]*a[q] - a[r]*a[s], row i holds {s, r, q, p}
    typedef logic [N_ELEM-1:0][3:0][3:0] cof_tab_t;

    localparam cof_tab_t COF_TAB = {
        {4'd3, 4'd1, 4'd4, 4'd0},
        {4'd7, 4'd0, 4'd6, 4'd1},
        {4'd6, 4'd4, 4'd7, 4'd3},
        {4'd5, 4'd0, 4'd3, 4'd2},
        {4'd6, 4'd2, 4'd8, 4'd0},
        {4'd8, 4'd3, 4'd6, 4'd5},
        {4'd4, 4'd2, 4'd5, 4'd1},
        {4'd8, 4'd1, 4'd7, 4'd2},
        {4'd7, 4'd5, 4'd8, 4'd4}
    };

    // determinant along the first row: a[j] times cofactor DET_TAB[j]
    typedef logic [2:0][3:0] det_tab_t;

    localparam det_tab_t DET_TAB = {4'd6, 4'd3, 4'd0};

endpackage

FILE: hw/rtl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Three-stage front end: input register, 18 element products, cofactor
// differences. Each stage holds its beat until the next stage frees up.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic [mi3_pkg::N_ELEM-1:0][ELEMENT_WIDTH-1:0]        in_elem,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [2:0][ELEMENT_WIDTH-1:0]                        out_row,
    output logic [mi3_pkg::N_ELEM-1:0][2*ELEMENT_WIDTH:0]        out_cof
);
    import mi3_pkg::*;

    localparam int W  = ELEMENT_WIDTH;
    localparam int NS = 3;

    logic [NS-1:0]         v_reg;
    logic [NS:0]           en;
    logic signed [W-1:0]   a_reg  [N_ELEM];
    logic signed [2*W-1:0] pa_reg [N_ELEM];
    logic signed [2*W-1:0] pb_reg [N_ELEM];
    logic [2:0][W-1:0]     row2_reg;
    logic [2:0][W-1:0]     row3_reg;
    logic [N_ELEM-1:0][2*W:0] cof_reg;

    always_comb
    begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                a_reg[i] <= in_elem[i];
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                pa_reg[i] <= a_reg[COF_TAB[i][0]] * a_reg[COF_TAB[i][1]];
                pb_reg[i] <= a_reg[COF_TAB[i][2]] * a_reg[COF_TAB[i][3]];
            end
            row2_reg <= {a_reg[2], a_reg[1], a_reg[0]};
        end
        if (en[2])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                cof_reg[i] <= {pa_reg[i][2*W-1], pa_reg[i]} - {pb_reg[i][2*W-1], pb_reg[i]};
            end
            row3_reg <= row2_reg;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_row   = row3_reg;
    assign out_cof   = cof_reg;

endmodule

FILE: hw/rtl/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Five-stage determinant unit: split partial products, term assembly,
// three-way sum, magnitude and sign, tolerance compare. Cofactor
// magnitudes and signs travel alongside for the divider.
// ----------------------------------------------------------------------------
module mi3_det #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic [mi3_pkg::TOL_WIDTH-1:0]                        tol,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic [2:0][ELEMENT_WIDTH-1:0]                        in_row,
    input  logic [mi3_pkg::N_ELEM-1:0][2*ELEMENT_WIDTH:0]        in_cof,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [mi3_pkg::N_ELEM-1:0][2*ELEMENT_WIDTH-1:0]      out_cmag,
    output logic [mi3_pkg::N_ELEM-1:0]                           out_cneg,
    output logic [3*ELEMENT_WIDTH:0]                             out_dmag,
    output logic                                                 out_dneg,
    output logic                                                 out_inv
);
    import mi3_pkg::*;

    localparam int W    = ELEMENT_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int NS   = 5;
    localparam int CW2  = 2 * W;
    localparam int DW   = 3 * W + 2;
    localparam int DMW  = DW - 1;
    localparam int CMPW = DMW + TOL_WIDTH + 3 * F;
    // |det| * 2^-3F <= tol * 2^-32, aligned to a common scale
    localparam int SH_T = (3 * F >= TOL_WIDTH) ? 3 * F - TOL_WIDTH : 0;
    localparam int SH_D = (3 * F >= TOL_WIDTH) ? 0 : TOL_WIDTH - 3 * F;

    logic [NS-1:0]              v_reg;
    logic [NS:0]                en;

    logic signed [2*W:0]        plo1_reg [3];
    logic signed [2*W:0]        phi1_reg [3];
    logic [N_ELEM-1:0][2*W:0]   cof1_reg;

    logic [DW-1:0]              term2_reg [3];
    logic [N_ELEM-1:0][CW2-1:0] cmag2_reg, cmag3_reg, cmag4_reg, cmag5_reg;
    logic [N_ELEM-1:0]          cneg2_reg, cneg3_reg, cneg4_reg, cneg5_reg;

    logic [DW-1:0]              det3_reg;
    logic [DMW-1:0]             dmag4_reg, dmag5_reg;
    logic                       dneg4_reg, dneg5_reg;
    logic                       inv5_reg;

    always_comb
    begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                if (en[s]) v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // cofactor split into a low unsigned half and a high signed half
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo1_reg[j] <= $signed(in_row[j])
                             * $signed({1'b0, in_cof[DET_TAB[j]][W-1:0]});
                phi1_reg[j] <= $signed(in_row[j]) * $signed(in_cof[DET_TAB[j]][2*W:W]);
            end
            cof1_reg <= in_cof;
        end
        if (en[1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                term2_reg[j] <= {phi1_reg[j][2*W], phi1_reg[j], {W{1'b0}}}
                              + {{(W+1){plo1_reg[j][2*W]}}, plo1_reg[j]};
            end
            for (int i = 0; i < N_ELEM; i++)
            begin
                cneg2_reg[i] <= cof1_reg[i][2*W];
                cmag2_reg[i] <= cof1_reg[i][2*W] ? CW2'(-cof1_reg[i]) : CW2'(cof1_reg[i]);
            end
        end
        if (en[2])
        begin
            det3_reg  <= term2_reg[0] + term2_reg[1] + term2_reg[2];
            cmag3_reg <= cmag2_reg;
            cneg3_reg <= cneg2_reg;
        end
        if (en[3])
        begin
            dneg4_reg <= det3_reg[DW-1];
            dmag4_reg <= det3_reg[DW-1] ? DMW'(-det3_reg) : DMW'(det3_reg);
            cmag4_reg <= cmag3_reg;
            cneg4_reg <= cneg3_reg;
        end
        if (en[4])
        begin
            inv5_reg  <= (CMPW'(dmag4_reg) << SH_D) > (CMPW'(tol) << SH_T);
            dmag5_reg <= dmag4_reg;
            dneg5_reg <= dneg4_reg;
            cmag5_reg <= cmag4_reg;
            cneg5_reg <= cneg4_reg;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_cmag  = cmag5_reg;
    assign out_cneg  = cneg5_reg;
    assign out_dmag  = dmag5_reg;
    assign out_dneg  = dneg5_reg;
    assign out_inv   = inv5_reg;

endmodule

FILE: hw/rtl/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// Nine-lane pipelined restoring divider: an overflow stage, one quotient
// bit per stage, a rounding stage and the saturating output register.
// ----------------------------------------------------------------------------
module mi3_div #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic [mi3_pkg::N_ELEM-1:0][2*ELEMENT_WIDTH-1:0]      in_cmag,
    input  logic [mi3_pkg::N_ELEM-1:0]                           in_cneg,
    input  logic [3*ELEMENT_WIDTH:0]                             in_dmag,
    input  logic                                                 in_dneg,
    input  logic                                                 in_inv,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [mi3_pkg::N_ELEM-1:0][ELEMENT_WIDTH-1:0]        out_elem,
    output logic                                                 out_inv,
    output logic                                                 out_sat
);
    import mi3_pkg::*;

    localparam int W   = ELEMENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int QW  = W + 1;
    localparam int DMW = 3 * W + 1;
    localparam int NW  = 2 * W + 2 * F;
    localparam int XW  = ((NW > DMW + QW) ? NW : DMW + QW) + 1;
    localparam int NS  = QW + 3;
    localparam int SR  = QW + 1;
    localparam int SO  = QW + 2;

    localparam logic [QW:0] LIM_NEG = (QW+1)'(1) << (W - 1);
    localparam logic [QW:0] LIM_POS = LIM_NEG - (QW+1)'(1);

    logic [NS-1:0]       v_reg;
    logic [NS:0]         en;

    logic [XW-1:0]       rem_reg  [QW+1][N_ELEM];
    logic [QW-1:0]       q_reg    [1:QW][N_ELEM];
    logic [DMW-1:0]      dmag_reg [QW+1];
    logic [N_ELEM-1:0]   ovf_reg  [QW+2];
    logic [N_ELEM-1:0]   neg_reg  [QW+2];
    logic                inv_reg  [QW+2];
    logic [QW:0]         qr_reg   [N_ELEM];

    logic [N_ELEM-1:0]   rnd;
    logic [N_ELEM-1:0]   sat_lane;
    logic [W-1:0]        res_lane [N_ELEM];

    logic [N_ELEM-1:0][W-1:0] elem_out_reg;
    logic                     inv_out_reg;
    logic                     sat_out_reg;

    always_comb
    begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                if (en[s]) v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // quotient of 2^2F * |cof| by |det| overflows when it reaches 2^QW
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                rem_reg[0][i] <= XW'(in_cmag[i]) << (2 * F);
                ovf_reg[0][i] <= (XW'(in_cmag[i]) << (2 * F)) >= (XW'(in_dmag) << QW);
                neg_reg[0][i] <= in_cneg[i] ^ in_dneg;
            end
            dmag_reg[0] <= in_dmag;
            inv_reg[0]  <= in_inv;
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_bit
        localparam int K = QW - s;

        logic [XW-1:0] dsh;
        logic [QW-1:0] qprev [N_ELEM];

        assign dsh = XW'(dmag_reg[s-1]) << K;

        if (s == 1)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < N_ELEM; i++)
                begin
                    qprev[i] = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int i = 0; i < N_ELEM; i++)
                begin
                    qprev[i] = q_reg[s-1][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                for (int i = 0; i < N_ELEM; i++)
                begin
                    if (rem_reg[s-1][i] >= dsh)
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i] - dsh;
                        q_reg[s][i]   <= {qprev[i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i];
                        q_reg[s][i]   <= {qprev[i][QW-2:0], 1'b0};
                    end
                end
                dmag_reg[s] <= dmag_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                inv_reg[s]  <= inv_reg[s-1];
            end
        end
    end

    // round half away from zero on the magnitude
    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            rnd[i] = (rem_reg[QW][i] << 1) >= XW'(dmag_reg[QW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SR])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                qr_reg[i] <= {1'b0, q_reg[QW][i]} + {{QW{1'b0}}, rnd[i]};
            end
            ovf_reg[SR] <= ovf_reg[QW];
            neg_reg[SR] <= neg_reg[QW];
            inv_reg[SR] <= inv_reg[QW];
        end
    end

    always_comb
    begin
        logic [QW:0] lim;
        logic [QW:0] mag;
        logic [QW:0] sval;
        for (int i = 0; i < N_ELEM; i++)
        begin
            lim         = neg_reg[SR][i] ? LIM_NEG : LIM_POS;
            sat_lane[i] = ovf_reg[SR][i] || (qr_reg[i] > lim);
            mag         = sat_lane[i] ? lim : qr_reg[i];
            sval        = neg_reg[SR][i] ? -mag : mag;
            res_lane[i] = sval[W-1:0];
        end
    end

    // singular matrices give zeros with the flags clear
    always_ff @(posedge clk)
    begin
        if (en[SO])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                elem_out_reg[i] <= inv_reg[SR] ? res_lane[i] : '0;
            end
            inv_out_reg <= inv_reg[SR];
            sat_out_reg <= inv_reg[SR] && (|sat_lane);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_elem  = elem_out_reg;
    assign out_inv   = inv_out_reg;
    assign out_sat   = sat_out_reg;

endmodule

FILE: hw/rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a 3x3 signed fixed-point matrix by the adjugate method.
//
// One matrix per beat on the s_ stream, one inverse per beat on the m_
// stream. s_tdata carries the nine elements row-major, r0c0 in the lowest
// bits; m_tdata carries the inverse in the same order, and m_tuser flags a
// nonsingular matrix and any clipped element.
// The singular tolerance is written through cfg_wr_en / cfg_wr_data
// between runs, in units of 2^-32 of determinant magnitude.
// The pipeline has three cofactor stages, five determinant stages and a divider
// of one quotient bit per stage plus overflow, rounding and output stages.
// Throughput is one matrix per cycle with m_tready high; each stage takes a
// new beat when it is empty or its contents move on, so bubbles close up under
// back-pressure and a stalled receiver holds m_tdata steady while the pipeline fills.
// Reset empties every stage and sets the tolerance to 429 (about 1e-7).
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16,
    localparam int TDATA_WIDTH  = ((mi3_pkg::N_ELEM * ELEMENT_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mi3_pkg::TOL_WIDTH-1:0]   cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, zero padding
    input  logic [TDATA_WIDTH-1:0]          s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0 .. out_r2c2, zero padding
    output logic [TDATA_WIDTH-1:0]          m_tdata,
    // invertible, saturated
    output logic [1:0]                      m_tuser
);
    import mi3_pkg::*;

    localparam int W = ELEMENT_WIDTH;

    logic [TOL_WIDTH-1:0]            tol_reg;
    logic [N_ELEM-1:0][W-1:0]        in_elem;

    logic                            cf_valid;
    logic                            cf_ready;
    logic [2:0][W-1:0]               cf_row;
    logic [N_ELEM-1:0][2*W:0]        cf_cof;

    logic                            dt_valid;
    logic                            dt_ready;
    logic [N_ELEM-1:0][2*W-1:0]      dt_cmag;
    logic [N_ELEM-1:0]               dt_cneg;
    logic [3*W:0]                    dt_dmag;
    logic                            dt_dneg;
    logic                            dt_inv;

    logic [N_ELEM-1:0][W-1:0]        dv_elem;
    logic                            dv_inv;
    logic                            dv_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    assign in_elem = s_tdata[N_ELEM*W-1:0];

    mi3_cofactor #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_elem   (in_elem),
        .out_valid (cf_valid),
        .out_ready (cf_ready),
        .out_row   (cf_row),
        .out_cof   (cf_cof)
    );

    mi3_det #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .in_valid  (cf_valid),
        .in_ready  (cf_ready),
        .in_row    (cf_row),
        .in_cof    (cf_cof),
        .out_valid (dt_valid),
        .out_ready (dt_ready),
        .out_cmag  (dt_cmag),
        .out_cneg  (dt_cneg),
        .out_dmag  (dt_dmag),
        .out_dneg  (dt_dneg),
        .out_inv   (dt_inv)
    );

    mi3_div #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dt_valid),
        .in_ready  (dt_ready),
        .in_cmag   (dt_cmag),
        .in_cneg   (dt_cneg),
        .in_dmag   (dt_dmag),
        .in_dneg   (dt_dneg),
        .in_inv    (dt_inv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_elem  (dv_elem),
        .out_inv   (dv_inv),
        .out_sat   (dv_sat)
    );

    assign m_tdata = TDATA_WIDTH'(dv_elem);
    assign m_tuser = {dv_sat, dv_inv};

endmodule

FILE: hw/rtl/mi3_checker.sv
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module mi3_checker #(
    parameter int TDATA_WIDTH = 288
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_WIDTH-1:0] m_tdata,
    input  logic [1:0]             m_tuser
);

    // a stalled output beat holds
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // with the output register empty every stage can move, so input is open
    a_open : assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output register");

    // singular matrices come out as zeros with saturation clear
    a_singular : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("singular beat carries data or saturation");

    // saturation only on an invertible matrix
    a_sat : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("saturation flagged on singular beat");

endmodule

bind matrix3x3_inverse mi3_checker #(
    .TDATA_WIDTH (TDATA_WIDTH)
) u_mi3_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse testbench
// Streams 3x3 Q16.16 matrices through the inverter under random bursts and
// receiver stalls, predicts each inverse with exact wide integer arithmetic
// and compares every output beat field by field, over several tolerances.
// ----------------------------------------------------------------------------
module testbench;

    localparam int EW     = 32;
    localparam int FB     = 16;
    localparam int TDW    = 288;
    localparam int LAT    = EW + 12;
    localparam int N_RAND = 1830;
    localparam int LIMIT  = 2000000;

    typedef logic signed [EW-1:0] elem_t;
    typedef elem_t mat_t [9];
    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [EW*9-1:0] elems;
        logic            invertible;
        logic            saturated;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDW-1:0] m_tdata;
    logic [1:0] m_tuser;

    logic [TDW-1:0] pending_beats[$];
    inverse_t       expected_inverses[$];
    logic [31:0]    tolerance;
    int  errors = 0;
    int  cycles = 0;
    int  hold_off = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  stall_pattern = 1'b0;

    matrix3x3_inverse dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 clk = ~clk;

    function automatic inverse_t invert_matrix(logic [TDW-1:0] beat);
        wide_t a[9];
        wide_t cof[9];
        wide_t det, dmag, num, q, r, lim, cmag;
        inverse_t res;
        bit neg;
        for (int i = 0; i < 9; i++)
            a[i] = wide_t'($signed(beat[i*EW +: EW]));
        cof[0] = a[4]*a[8] - a[5]*a[7];
        cof[1] = a[2]*a[7] - a[1]*a[8];
        cof[2] = a[1]*a[5] - a[2]*a[4];
        cof[3] = a[5]*a[6] - a[3]*a[8];
        cof[4] = a[0]*a[8] - a[2]*a[6];
        cof[5] = a[2]*a[3] - a[0]*a[5];
        cof[6] = a[3]*a[7] - a[4]*a[6];
        cof[7] = a[1]*a[6] - a[0]*a[7];
        cof[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
        dmag = det < 0 ? -det : det;
        res.elems = '0;
        res.invertible = 1'b0;
        res.saturated = 1'b0;
        // tolerance is in 2^-32, determinant in 2^-48
        if (dmag <= (wide_t'(tolerance) <<< (3*FB - 32)))
            return res;
        res.invertible = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            cmag = cof[i] < 0 ? -cof[i] : cof[i];
            num = cmag <<< (2*FB);
            q = num / dmag;
            r = num % dmag;
            if (2*r >= dmag)
                q = q + 1;
            neg = (cof[i] < 0) != (det < 0);
            lim = neg ? (wide_t'(1) <<< (EW-1)) : (wide_t'(1) <<< (EW-1)) - 1;
            if (q > lim)
            begin
                q = lim;
                res.saturated = 1'b1;
            end
            if (neg)
                q = -q;
            res.elems[i*EW +: EW] = q[EW-1:0];
        end
        return res;
    endfunction

    // sender: bursts and gaps, a bursty valid held until accepted
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_inverses.push_back(invert_matrix(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_beats.pop_front();
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    stall_pattern <= ~stall_pattern;
                m_tready <= stall_pattern ? ($urandom_range(0, 3) == 0) : 1'b1;
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_inverses.size() == 0)
            begin
                $display("%0t: unexpected beat %h user %b", $time, m_tdata, m_tuser);
                errors = errors + 1;
            end
            else
            begin
                inverse_t want;
                want = expected_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[i*EW +: EW] !== want.elems[i*EW +: EW])
                    begin
                        $display("%0t: element %0d expected %h actual %h", $time, i,
                                 want.elems[i*EW +: EW], m_tdata[i*EW +: EW]);
                        errors = errors + 1;
                    end
                if (m_tuser[0] !== want.invertible)
                begin
                    $display("%0t: invertible expected %b actual %b", $time,
                             want.invertible, m_tuser[0]);
                    errors = errors + 1;
                end
                if (m_tuser[1] !== want.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, m_tuser[1]);
                    errors = errors + 1;
                end
            end
        end
        if (cycles >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [TDW-1:0] pack_matrix(mat_t m);
        logic [TDW-1:0] b;
        b = '0;
        for (int i = 0; i < 9; i++)
            b[i*EW +: EW] = m[i];
        return b;
    endfunction

    function automatic elem_t random_elem(int style);
        case (style)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
            2: return elem_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff);
            default: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
        endcase
    endfunction

    function automatic logic [TDW-1:0] random_matrix();
        mat_t m;
        int style, kind;
        style = $urandom_range(0, 9) < 1 ? 0 : ($urandom_range(0, 9) == 0 ? 3 : $urandom_range(1, 2));
        for (int i = 0; i < 9; i++)
            m[i] = ($urandom_range(0, 19) == 0) ? random_elem(3) : random_elem(style);
        kind = $urandom_range(0, 9);
        // singular by construction: a repeated or zero row
        if (kind == 0)
            for (int c = 0; c < 3; c++)
                m[6+c] = m[c];
        else if (kind == 1)
            for (int c = 0; c < 3; c++)
                m[3+c] = '0;
        // near-identity scaled tiny, to land near the tolerance
        else if (kind == 2)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = elem_t'($signed($urandom_range(0, 15)) - 8);
            m[0] = $urandom_range(1, 200);
            m[4] = $urandom_range(1, 200);
            m[8] = $urandom_range(1, 200);
        end
        return pack_matrix(m);
    endfunction

    task automatic drain(int extra);
        wait (pending_beats.size() == 0 && !s_tvalid);
        wait (expected_inverses.size() == 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [31:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        tolerance <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        mat_t m;
        logic [31:0] tols[5];
        tolerance = 32'd429;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity, extremes, singular, tiny and saturating inverses
        m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
        pending_beats.push_back(pack_matrix(m));
        m = '{32'sh7fffffff, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh7fffffff};
        pending_beats.push_back(pack_matrix(m));
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        pending_beats.push_back(pack_matrix(m));
        m = '{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100};
        pending_beats.push_back(pack_matrix(m));
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        pending_beats.push_back(pack_matrix(m));
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        pending_beats.push_back(pack_matrix(m));
        m = '{32'sh80000000, 32'sh7fffffff, 1, 2, 32'sh80000000, 3, 5, 7, 32'sh80000000};
        pending_beats.push_back(pack_matrix(m));
        m = '{32'sh20000, 32'sh10000, 0, 32'sh10000, 32'sh20000, 32'sh10000,
              0, 32'sh10000, 32'sh20000};
        pending_beats.push_back(pack_matrix(m));
        m = '{3, 0, 0, 0, 1, 0, 0, 0, 1};
        pending_beats.push_back(pack_matrix(m));
        m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000, 32'sh60000,
              32'sh70000, 32'sh80000, 32'sh90000};
        pending_beats.push_back(pack_matrix(m));
        m = '{32'shfffeffff, 0, 0, 0, 32'shffff0000, 0, 0, 0, 32'sh7fff0000};
        pending_beats.push_back(pack_matrix(m));
        drain(LAT);

        tols = '{32'd0, 32'hffffffff, 32'd1, 32'd65536, 32'd429};
        for (int p = 0; p < 5; p++)
        begin
            write_tolerance(tols[p]);
            for (int n = 0; n < N_RAND / 5; n++)
                pending_beats.push_back(random_matrix());
            if (p == 1)
                hold_off <= 300;
            drain(LAT);
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
